// File: rtl/cgn_pkg.sv
`default_nettype none
package cgn_pkg;

    // Frame size limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 12;
    localparam logic [SIZE_W-1:0] MIN_SIZE     = 12'd3;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd480;

    // Pixel data widths
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 22;
    localparam int MAG_W   = 8;
    localparam int SEC_W   = 2;
    localparam int ENTRY_W = MAG_W + SEC_W;
    localparam int BIT_W   = $clog2(MAG_W);

    // Magnitude saturation threshold: at or above this n, round(sqrt(n)) >= 255
    localparam logic [SQ_W-1:0] SAT_N = 22'd65281;

    // Direction sectors
    localparam logic [SEC_W-1:0] SEC_0   = 2'd0;
    localparam logic [SEC_W-1:0] SEC_45  = 2'd1;
    localparam logic [SEC_W-1:0] SEC_90  = 2'd2;
    localparam logic [SEC_W-1:0] SEC_135 = 2'd3;

    // Register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic root_step;
        logic finish;
        logic supp;
        logic second;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic root_last;
        logic emit;
        logic last_col;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/canny_gradient_nms.sv
`default_nettype none
// Canny gradient magnitude, four-sector direction and non-maximum suppression.
// Input channel s_*: one Sobel pair (grad_x, grad_y) per item, raster order.
// Result channel m_*: suppressed magnitude, sector and row/frame/run flags.
// The results of a frame lag one row and one column; row 0 gives none, and
// the last column of every later row gives a second, closing result.
// From acceptance to its first result, each item passes through load,
// square, eight steps of the shared bit-by-bit square root, finish (line
// store write and window shift), suppression, then the result. An item
// that gives no result frees the input after suppression; a last-column item
// holds it until both of its results are taken.
// The input is taken only while no result is pending; when the receiver
// stalls, the held result stays on m_* and the input waits.
// Configuration (cfg_wr_en, cfg_index, cfg_wr_data) writes image_width
// (index 0) or image_height (index 1) and restarts the frame at (0, 0);
// write only while idle. Reset loads 640 x 480 and position (0, 0); the line
// stores need no clearing.
module canny_gradient_nms (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [cgn_pkg::SIZE_W-1:0]        cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [cgn_pkg::GRAD_W-1:0] s_grad_x,
    input  wire logic signed [cgn_pkg::GRAD_W-1:0] s_grad_y,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [cgn_pkg::MAG_W-1:0]              m_edge_value,
    output logic [cgn_pkg::SEC_W-1:0]              m_dir_sector,
    output logic                                   m_end_of_row,
    output logic                                   m_end_of_frame,
    output logic                                   m_last_in_run
);

    cgn_pkg::cmd_t    cmd;
    cgn_pkg::status_t status;

    cgn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cgn_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_grad_x       (s_grad_x),
        .s_grad_y       (s_grad_y),
        .m_edge_value   (m_edge_value),
        .m_dir_sector   (m_dir_sector),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame),
        .m_last_in_run  (m_last_in_run)
    );

endmodule
`default_nettype wire

// File: rtl/cgn_ram.sv
`default_nettype none
module cgn_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/cgn_ctrl.sv
`default_nettype none
module cgn_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire cgn_pkg::status_t  status,
    output cgn_pkg::cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_SUPP = 3'd4;
    localparam logic [2:0] ST_OUT1 = 3'd5;
    localparam logic [2:0] ST_OUT2 = 3'd6;

    logic [2:0] state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.root_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_SUPP;
            end
            ST_SUPP: begin
                cmd.supp   = 1'b1;
                state_next = status.emit ? ST_OUT1 : ST_IDLE;
            end
            ST_OUT1: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = status.last_col ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2: begin
                m_valid    = 1'b1;
                cmd.second = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // Input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // The root iteration ends in the finish step
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && status.root_last) |=> (state_reg == ST_FIN))
        else $error("root iteration did not finish");

    // The second result only follows the first one of a last-column item
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT2) |->
            ($past(state_reg) == ST_OUT1 || $past(state_reg) == ST_OUT2))
        else $error("second result out of order");

    // An accepted item starts its squaring step
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQ))
        else $error("accepted item not started");
`endif

endmodule
`default_nettype wire

// File: rtl/cgn_dp.sv
`default_nettype none
module cgn_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cgn_pkg::cmd_t                     cmd,
    output cgn_pkg::status_t                       status,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [cgn_pkg::SIZE_W-1:0]        cfg_wr_data,
    input  wire logic signed [cgn_pkg::GRAD_W-1:0] s_grad_x,
    input  wire logic signed [cgn_pkg::GRAD_W-1:0] s_grad_y,
    output logic [cgn_pkg::MAG_W-1:0]              m_edge_value,
    output logic [cgn_pkg::SEC_W-1:0]              m_dir_sector,
    output logic                                   m_end_of_row,
    output logic                                   m_end_of_frame,
    output logic                                   m_last_in_run
);

    localparam int COL_W   = cgn_pkg::COL_W;
    localparam int ROW_W   = cgn_pkg::ROW_W;
    localparam int SIZE_W  = cgn_pkg::SIZE_W;
    localparam int GRAD_W  = cgn_pkg::GRAD_W;
    localparam int SQ_W    = cgn_pkg::SQ_W;
    localparam int MAG_W   = cgn_pkg::MAG_W;
    localparam int SEC_W   = cgn_pkg::SEC_W;
    localparam int ENTRY_W = cgn_pkg::ENTRY_W;
    localparam int BIT_W   = cgn_pkg::BIT_W;

    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   icol_reg;
    logic [ROW_W-1:0]   irow_reg;
    logic [GRAD_W-1:0]  ax_reg, ay_reg;
    logic               opp_reg;
    logic [SEC_W-1:0]   sec_reg;
    logic [SQ_W-1:0]    n_reg;
    logic [MAG_W-1:0]   k_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [ENTRY_W-1:0] win_reg [0:2][0:2];
    logic [MAG_W-1:0]   edge_reg;
    logic [SEC_W-1:0]   dir_reg;

    logic [SIZE_W-1:0]  w_eff, h_eff, wm1, hm1;
    logic [COL_W-1:0]   col_eff;
    logic [ROW_W-1:0]   row_eff;
    logic [ENTRY_W-1:0] up_rdata, mid_rdata;
    logic [ENTRY_W-1:0] entry;
    logic [MAG_W-1:0]   k_try, k_fin, mag_in, supp_mag;
    logic [2*MAG_W-1:0] k_try_sq;
    logic [2*MAG_W:0]   k_round;
    logic [20:0]        ay256, ax106, ax618;
    logic               interior_in, interior_out;
    logic [ENTRY_W-1:0] center, nb_a, nb_b;

    // Effective frame size, clamped
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < cgn_pkg::MIN_SIZE) r = cgn_pkg::MIN_SIZE;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [GRAD_W-1:0] abs_of(input logic [GRAD_W-1:0] v);
        return v[GRAD_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_eff   = clamp_size(width_reg, SIZE_W'(cgn_pkg::MAX_WIDTH));
    assign h_eff   = clamp_size(height_reg, SIZE_W'(cgn_pkg::MAX_HEIGHT));
    assign wm1     = w_eff - 1'b1;
    assign hm1     = h_eff - 1'b1;
    assign col_eff = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign row_eff = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;

    // Line stores
    cgn_ram #(.WIDTH(ENTRY_W), .DEPTH(cgn_pkg::MAX_WIDTH)) u_upper (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (icol_reg),
        .wdata (mid_rdata),
        .raddr (icol_reg),
        .rdata (up_rdata)
    );

    cgn_ram #(.WIDTH(ENTRY_W), .DEPTH(cgn_pkg::MAX_WIDTH)) u_middle (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (icol_reg),
        .wdata (entry),
        .raddr (icol_reg),
        .rdata (mid_rdata)
    );

    // Sector thresholds
    assign ay256 = {2'b00, ay_reg, 8'd0};
    assign ax106 = 21'(ax_reg) * 21'd106;
    assign ax618 = 21'(ax_reg) * 21'd618;

    // Square root trial bit
    assign k_try    = k_reg | (MAG_W'(1) << bit_reg);
    assign k_try_sq = (2*MAG_W)'(k_try) * (2*MAG_W)'(k_try);

    // Rounding and entry formation
    assign k_round     = (2*MAG_W+1)'(k_reg) * (2*MAG_W+1)'(k_reg) + (2*MAG_W+1)'(k_reg);
    assign k_fin       = (n_reg >= cgn_pkg::SAT_N) ? {MAG_W{1'b1}} :
                         ((n_reg > SQ_W'(k_round)) ? k_reg + 1'b1 : k_reg);
    assign interior_in = (irow_reg != '0) && ({1'b0, irow_reg} != hm1) &&
                         (icol_reg != '0) && ({1'b0, icol_reg} != wm1);
    assign mag_in      = interior_in ? k_fin : '0;
    assign entry       = {mag_in, sec_reg};

    // Suppression along the center's sector
    assign center = win_reg[1][1];
    always_comb begin
        case (center[SEC_W-1:0])
            cgn_pkg::SEC_0: begin
                nb_a = win_reg[1][0];
                nb_b = win_reg[1][2];
            end
            cgn_pkg::SEC_45: begin
                nb_a = win_reg[0][2];
                nb_b = win_reg[2][0];
            end
            cgn_pkg::SEC_90: begin
                nb_a = win_reg[0][1];
                nb_b = win_reg[2][1];
            end
            default: begin
                nb_a = win_reg[0][0];
                nb_b = win_reg[2][2];
            end
        endcase
    end
    assign supp_mag = (center[ENTRY_W-1:SEC_W] > nb_a[ENTRY_W-1:SEC_W] &&
                       center[ENTRY_W-1:SEC_W] > nb_b[ENTRY_W-1:SEC_W]) ?
                      center[ENTRY_W-1:SEC_W] : '0;
    assign interior_out = (irow_reg >= ROW_W'(2)) && (icol_reg >= COL_W'(2));

    // Status
    assign status.root_last = (bit_reg == '0);
    assign status.emit      = (irow_reg != '0) && (icol_reg != '0);
    assign status.last_col  = ({1'b0, icol_reg} == wm1);

    // Next position
    always_comb begin
        col_next = icol_reg + 1'b1;
        row_next = irow_reg;
        if ({1'b0, icol_reg} == wm1) begin
            col_next = '0;
            row_next = ({1'b0, irow_reg} == hm1) ? '0 : irow_reg + 1'b1;
        end
    end

    // Configuration and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cgn_pkg::RESET_WIDTH;
            height_reg <= cgn_pkg::RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == cgn_pkg::REG_WIDTH) width_reg <= cfg_wr_data;
            if (cfg_index == cgn_pkg::REG_HEIGHT) height_reg <= cfg_wr_data;
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.finish) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Per-item datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            icol_reg <= col_eff;
            irow_reg <= row_eff;
            ax_reg   <= abs_of(s_grad_x);
            ay_reg   <= abs_of(s_grad_y);
            opp_reg  <= s_grad_x[GRAD_W-1] ^ s_grad_y[GRAD_W-1];
        end
        if (cmd.square) begin
            n_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg) + SQ_W'(ay_reg) * SQ_W'(ay_reg);
            k_reg   <= '0;
            bit_reg <= BIT_W'(MAG_W - 1);
            if (ay256 <= ax106) sec_reg <= cgn_pkg::SEC_0;
            else if (ay256 <= ax618) sec_reg <= opp_reg ? cgn_pkg::SEC_135 : cgn_pkg::SEC_45;
            else sec_reg <= cgn_pkg::SEC_90;
        end
        if (cmd.root_step) begin
            if (SQ_W'(k_try_sq) <= n_reg) k_reg <= k_try;
            bit_reg <= bit_reg - 1'b1;
        end
        if (cmd.finish) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_rdata;
            win_reg[1][2] <= mid_rdata;
            win_reg[2][2] <= entry;
        end
        if (cmd.supp) begin
            edge_reg <= interior_out ? supp_mag : '0;
            dir_reg  <= interior_out ? center[SEC_W-1:0] : cgn_pkg::SEC_0;
        end
    end

    // Result payload; the second result closes the row
    assign m_edge_value   = cmd.second ? '0 : edge_reg;
    assign m_dir_sector   = cmd.second ? cgn_pkg::SEC_0 : dir_reg;
    assign m_end_of_row   = cmd.second;
    assign m_end_of_frame = cmd.second && ({1'b0, irow_reg} == hm1);
    assign m_last_in_run  = cmd.second || !status.last_col;

endmodule
`default_nettype wire

// File: tb/canny_gradient_nms_test.sv
`timescale 1ns / 1ps
`default_nettype none

module canny_gradient_nms_test;

    localparam int MAG_W      = cgn_pkg::MAG_W;
    localparam int SEC_W      = cgn_pkg::SEC_W;
    localparam int SIZE_W     = cgn_pkg::SIZE_W;
    localparam int GRAD_W     = cgn_pkg::GRAD_W;
    localparam int ENTRY_W    = cgn_pkg::ENTRY_W;
    localparam int MAX_WIDTH  = cgn_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = cgn_pkg::MAX_HEIGHT;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [SEC_W-1:0] sector;
        logic             eor;
        logic             eof;
        logic             lir;
    } edge_result_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic cfg_index;
    logic [SIZE_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic signed [GRAD_W-1:0] s_grad_x;
    logic signed [GRAD_W-1:0] s_grad_y;
    logic m_valid;
    logic m_ready;
    logic [MAG_W-1:0] m_edge_value;
    logic [SEC_W-1:0] m_dir_sector;
    logic m_end_of_row;
    logic m_end_of_frame;
    logic m_last_in_run;

    canny_gradient_nms u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_grad_x       (s_grad_x),
        .s_grad_y       (s_grad_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_edge_value   (m_edge_value),
        .m_dir_sector   (m_dir_sector),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame),
        .m_last_in_run  (m_last_in_run)
    );

    // Clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predictor state: size registers, raster position, line stores, window
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    int                 col_pos;
    int                 row_pos;
    logic [ENTRY_W-1:0] upper_line [MAX_WIDTH];
    logic [ENTRY_W-1:0] middle_line [MAX_WIDTH];
    logic [ENTRY_W-1:0] win [3][3];

    edge_result_t pending_edges[$];
    int send_idle_pct;
    int recv_idle_pct;
    int n_items;
    int n_edges;
    int n_errors;
    int n_cfg;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d: %s got %0d expected %0d", n_edges, what, got, want);
        n_errors++;
    endtask

    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < cgn_pkg::MIN_SIZE) return cgn_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // round(sqrt(n)), saturated at 255
    function automatic int round_root(input int n);
        int k;
        if (n >= cgn_pkg::SAT_N) return 255;
        k = 0;
        for (int b = 128; b != 0; b = b >> 1) begin
            if ((k | b) * (k | b) <= n) k = k | b;
        end
        if (n > k * k + k) k++;
        return k;
    endfunction

    // Zero unless the center strictly exceeds both neighbors along its sector
    function automatic logic [MAG_W-1:0] nms_value();
        logic [ENTRY_W-1:0] a;
        logic [ENTRY_W-1:0] b;
        logic [MAG_W-1:0]   m;
        m = win[1][1][ENTRY_W-1:SEC_W];
        case (win[1][1][SEC_W-1:0])
            cgn_pkg::SEC_0: begin
                a = win[1][0];
                b = win[1][2];
            end
            cgn_pkg::SEC_45: begin
                a = win[0][2];
                b = win[2][0];
            end
            cgn_pkg::SEC_90: begin
                a = win[0][1];
                b = win[2][1];
            end
            default: begin
                a = win[0][0];
                b = win[2][2];
            end
        endcase
        if (m <= a[ENTRY_W-1:SEC_W] || m <= b[ENTRY_W-1:SEC_W]) return '0;
        return m;
    endfunction

    // Advance the predictor by one accepted item and queue its results
    task automatic predict_edges(input logic signed [GRAD_W-1:0] gx,
                                 input logic signed [GRAD_W-1:0] gy);
        int w, h, c, r, ax, ay;
        logic [SEC_W-1:0]   sec;
        logic [ENTRY_W-1:0] ent;
        logic               last;
        logic               interior;
        edge_result_t       res;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        ax = gx < 0 ? -int'(gx) : int'(gx);
        ay = gy < 0 ? -int'(gy) : int'(gy);
        if (256 * ay <= 106 * ax) sec = cgn_pkg::SEC_0;
        else if (256 * ay <= 618 * ax)
            sec = (gx[GRAD_W-1] ^ gy[GRAD_W-1]) ? cgn_pkg::SEC_135 : cgn_pkg::SEC_45;
        else sec = cgn_pkg::SEC_90;
        ent = {MAG_W'(0), sec};
        if (r != 0 && r != h - 1 && c != 0 && c != w - 1)
            ent[ENTRY_W-1:SEC_W] = MAG_W'(round_root(ax * ax + ay * ay));
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = ent;
        upper_line[c] = middle_line[c];
        middle_line[c] = ent;
        if (r >= 1 && c >= 1) begin
            last = (c == w - 1);
            interior = (r >= 2 && c >= 2);
            res.mag = interior ? nms_value() : '0;
            res.sector = interior ? win[1][1][SEC_W-1:0] : cgn_pkg::SEC_0;
            res.eor = 1'b0;
            res.eof = 1'b0;
            res.lir = !last;
            pending_edges.push_back(res);
            if (last) begin
                res = '{mag: '0, sector: cgn_pkg::SEC_0, eor: 1'b1, eof: (r == h - 1),
                        lir: 1'b1};
                pending_edges.push_back(res);
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // Receiver: random stall, then check each accepted result
    always @(posedge aclk) begin
        edge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_edges.pop_front();
                if (m_edge_value !== want.mag)
                    report_mismatch("edge_value", m_edge_value, want.mag);
                if (m_dir_sector !== want.sector)
                    report_mismatch("dir_sector", m_dir_sector, want.sector);
                if (m_end_of_row !== want.eor)
                    report_mismatch("end_of_row", m_end_of_row, want.eor);
                if (m_end_of_frame !== want.eof)
                    report_mismatch("end_of_frame", m_end_of_frame, want.eof);
                if (m_last_in_run !== want.lir)
                    report_mismatch("last_in_run", m_last_in_run, want.lir);
            end
            n_edges++;
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one item; valid stays high afterwards until the next call or a drain
    task automatic send_pixel(input logic signed [GRAD_W-1:0] gx,
                              input logic signed [GRAD_W-1:0] gy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_grad_x <= gx;
        s_grad_y <= gy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_edges(gx, gy);
        n_items++;
    endtask

    // Hold the input until every expected result is in, then let the pipe settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_size(input logic idx, input logic [SIZE_W-1:0] val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == cgn_pkg::REG_WIDTH) width_reg = val;
        else height_reg = val;
        col_pos = 0;
        row_pos = 0;
        n_cfg++;
    endtask

    function automatic logic signed [GRAD_W-1:0] rand_grad();
        if ($urandom_range(9) < 3) return GRAD_W'($urandom);
        if ($urandom_range(9) < 5) return GRAD_W'($urandom_range(80)) - 11'sd40;
        return GRAD_W'($urandom_range(2040)) - 11'sd1020;
    endfunction

    // Reset size: the first row gives nothing, then the start of row one
    task automatic test_reset_size();
        repeat (645) send_pixel(rand_grad(), rand_grad());
    endtask

    // Field extremes, sector boundary ties and the saturation point on 4 x 4
    task automatic test_directed();
        logic signed [GRAD_W-1:0] vx [20];
        logic signed [GRAD_W-1:0] vy [20];
        vx = '{11'sd1023, -11'sd1024, 11'sd0, 11'sd0, 11'sd128, 11'sd128, -11'sd128,
               11'sd255, 11'sd254, 11'sd1020, -11'sd1020, 11'sd5, -11'sd7, 11'sd0,
               11'sd300, 11'sd1, -11'sd1, 11'sd128, -11'sd128, 11'sd0};
        vy = '{-11'sd1024, 11'sd1023, 11'sd0, 11'sd1023, 11'sd53, 11'sd309, 11'sd309,
               11'sd16, 11'sd16, 11'sd1020, -11'sd1020, 11'sd5, 11'sd7, -11'sd1024,
               -11'sd1, -11'sd1, 11'sd0, 11'sd54, 11'sd310, 11'sd0};
        write_size(cgn_pkg::REG_WIDTH, 12'd4);
        write_size(cgn_pkg::REG_HEIGHT, 12'd4);
        for (int i = 0; i < 20; i++) send_pixel(vx[i], vy[i]);
        // pause with the second frame one row in
        drain_results();
        for (int i = 0; i < 12; i++) send_pixel(vx[19 - i], vy[i]);
    endtask

    // Out-of-range sizes clamp to 3 and to the maximum; a wide frame shows
    // no result within the first part of its top row
    task automatic test_size_clamp();
        write_size(cgn_pkg::REG_WIDTH, 12'd0);
        write_size(cgn_pkg::REG_HEIGHT, 12'd1);
        repeat (20) send_pixel(rand_grad(), rand_grad());
        write_size(cgn_pkg::REG_WIDTH, 12'd2);
        write_size(cgn_pkg::REG_HEIGHT, 12'd4095);
        repeat (15) send_pixel(rand_grad(), rand_grad());
        write_size(cgn_pkg::REG_WIDTH, 12'd4095);
        write_size(cgn_pkg::REG_HEIGHT, 12'd2);
        repeat (30) send_pixel(rand_grad(), rand_grad());
        write_size(cgn_pkg::REG_WIDTH, 12'd2048);
        write_size(cgn_pkg::REG_HEIGHT, 12'd2048);
        repeat (30) send_pixel(rand_grad(), rand_grad());
    endtask

    // Random frames on small sizes, sizes changed at random points
    task automatic test_random_frames(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0) begin
                write_size(cgn_pkg::REG_WIDTH, SIZE_W'($urandom_range(12, 3)));
                write_size(cgn_pkg::REG_HEIGHT, SIZE_W'($urandom_range(6, 3)));
            end
            send_pixel(rand_grad(), rand_grad());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = cgn_pkg::REG_WIDTH;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_grad_x = '0;
        s_grad_y = '0;
        m_ready = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 49;
        n_items = 0;
        n_edges = 0;
        n_errors = 0;
        n_cfg = 0;
        width_reg = cgn_pkg::RESET_WIDTH;
        height_reg = cgn_pkg::RESET_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_directed();
        test_size_clamp();
        write_size(cgn_pkg::REG_WIDTH, 12'd3);
        write_size(cgn_pkg::REG_HEIGHT, 12'd3);
        test_random_frames(80);
        send_idle_pct = 49;
        recv_idle_pct = 9;
        test_random_frames(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(80);

        drain_results();
        repeat (30) @(posedge aclk);
        $display("Sent %0d gradient items over %0d size writes; checked %0d results.",
                 n_items, n_cfg, n_edges);
        $display("Covered reset size, clamped sizes, directed corner values and random small frames.");
        if (n_errors == 0 && pending_edges.size() == 0) begin
            $display("canny_gradient_nms_test passed");
        end else begin
            $display("canny_gradient_nms_test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending_edges.size());
        $display("canny_gradient_nms_test failed");
        $finish;
    end

endmodule

`default_nettype wire
